@@ hdl/blbq_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// blbq_pkg
// Shared codes for the Butterworth low-pass biquad: operation codes and
// control register indexes.
// ----------------------------------------------------------------------------
package blbq_pkg;

   localparam int CSR_ADDR_W = 2;

   localparam logic [CSR_ADDR_W-1:0] CSR_FF_GAIN     = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_FB_COEF_ONE = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_FB_COEF_TWO = 2'd2;

   localparam logic OP_FILTER = 1'b0;
   localparam logic OP_PRESET = 1'b1;

endpackage
`default_nettype wire

@@ hdl/blbq_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// blbq_datapath
// Direct form I multiply-accumulate with half-up rounding and saturation,
// or pass-through of the preset value.
// ----------------------------------------------------------------------------
module blbq_datapath #(
   parameter int SAMPLE_WIDTH   = 24,
   parameter int COEF_FRAC_BITS = 22
) (
   input  logic                             op,
   input  logic signed [SAMPLE_WIDTH-1:0]   sample,
   input  logic signed [SAMPLE_WIDTH-1:0]   in_hist_one,
   input  logic signed [SAMPLE_WIDTH-1:0]   in_hist_two,
   input  logic signed [SAMPLE_WIDTH-1:0]   out_hist_one,
   input  logic signed [SAMPLE_WIDTH-1:0]   out_hist_two,
   input  logic signed [COEF_FRAC_BITS+2:0] ff_gain,
   input  logic signed [COEF_FRAC_BITS+2:0] fb_coef_one,
   input  logic signed [COEF_FRAC_BITS+2:0] fb_coef_two,
   output logic signed [SAMPLE_WIDTH-1:0]   filtered,
   output logic                             clipped
);

   localparam int SW  = SAMPLE_WIDTH;
   localparam int CW  = COEF_FRAC_BITS + 3;
   localparam int TW  = SW + 2;
   localparam int PFW = CW + TW;
   localparam int PBW = CW + SW;
   localparam int AW  = CW + SW + 4;
   localparam int RW  = AW - COEF_FRAC_BITS;

   localparam logic signed [AW-1:0] HALF = AW'(1) <<< (COEF_FRAC_BITS - 1);
   localparam logic signed [SW-1:0] MAXV = {1'b0, {(SW-1){1'b1}}};
   localparam logic signed [SW-1:0] MINV = {1'b1, {(SW-1){1'b0}}};

   logic signed [TW-1:0]  taps;
   logic signed [PFW-1:0] prod_ff;
   logic signed [PBW-1:0] prod_one;
   logic signed [PBW-1:0] prod_two;
   logic signed [AW-1:0]  acc;
   logic signed [RW-1:0]  rounded;
   logic [RW-SW:0]        top_bits;
   logic                  fits;

   assign taps     = TW'(sample) + (TW'(in_hist_one) <<< 1) + TW'(in_hist_two);
   assign prod_ff  = ff_gain * taps;
   assign prod_one = fb_coef_one * out_hist_one;
   assign prod_two = fb_coef_two * out_hist_two;
   assign acc      = AW'(prod_ff) - AW'(prod_one) - AW'(prod_two) + HALF;
   assign rounded  = acc[AW-1:COEF_FRAC_BITS];
   assign top_bits = rounded[RW-1:SW-1];
   assign fits     = (&top_bits) | ~(|top_bits);

   always_comb begin
      filtered = sample;
      clipped  = 1'b0;
      if (op == blbq_pkg::OP_FILTER) begin
         if (fits) begin
            filtered = rounded[SW-1:0];
         end else begin
            filtered = rounded[RW-1] ? MINV : MAXV;
            clipped  = 1'b1;
         end
      end
   end

endmodule
`default_nettype wire

@@ hdl/butterworth_lowpass_biquad_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// butterworth_lowpass_biquad_top
// Second-order Butterworth low-pass, direct form I, fixed point.
//
// Requests arrive on req_*: tdata carries the signed sample, tuser the
// operation (filter, or preset all four history taps to the sample).
// Results leave on rsp_*: tdata carries the saturated output, tuser the
// clip flag. Coefficients (Q2.22) are written on csr_* while idle.
// A request is held in an input register; the whole product sum, rounding
// and saturation are combinational, and when the request advances the
// result register and the history taps are loaded.
// Throughput: one request per cycle while results are taken, set by the
// combinational three-multiplier accumulate closing the output feedback loop.
// If rsp_tready is low, the result register holds, the input register
// fills, and req_tready drops until the result is taken.
// Synchronous reset clears coefficients, history and both valid flags.
// ----------------------------------------------------------------------------
module butterworth_lowpass_biquad_top #(
   parameter int SAMPLE_WIDTH   = 24,
   parameter int COEF_FRAC_BITS = 22
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]     req_tdata,  // sample
   input  logic                                  req_tuser,  // op
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]     rsp_tdata,  // filtered
   output logic                                  rsp_tuser,  // clipped
   input  logic                                  csr_wr_en,
   input  logic [blbq_pkg::CSR_ADDR_W-1:0]       csr_addr,
   input  logic [COEF_FRAC_BITS+2:0]             csr_wdata
);

   localparam int SW  = SAMPLE_WIDTH;
   localparam int CW  = COEF_FRAC_BITS + 3;
   localparam int RDW = ((SAMPLE_WIDTH + 7) / 8) * 8;

   logic                 s1_valid_ff, s1_valid_in;
   logic                 s1_op_ff;
   logic signed [SW-1:0] s1_sample_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [SW-1:0]        rsp_filtered_ff;
   logic                 rsp_clipped_ff;

   logic signed [CW-1:0] ff_gain_ff, fb_coef_one_ff, fb_coef_two_ff;
   logic signed [SW-1:0] in_hist_one_ff, in_hist_two_ff;
   logic signed [SW-1:0] out_hist_one_ff, out_hist_two_ff;

   logic                 advance;
   logic                 req_accept;
   logic signed [SW-1:0] dp_filtered;
   logic                 dp_clipped;

   assign advance    = s1_valid_ff & (~rsp_valid_ff | rsp_tready);
   assign req_tready = ~s1_valid_ff | advance;
   assign req_accept = req_tvalid & req_tready;

   assign s1_valid_in  = req_accept | (s1_valid_ff & ~advance);
   assign rsp_valid_in = advance | (rsp_valid_ff & ~rsp_tready);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RDW'(rsp_filtered_ff);
   assign rsp_tuser  = rsp_clipped_ff;

   blbq_datapath #(
      .SAMPLE_WIDTH   (SAMPLE_WIDTH),
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_datapath (
      .op           (s1_op_ff),
      .sample       (s1_sample_ff),
      .in_hist_one  (in_hist_one_ff),
      .in_hist_two  (in_hist_two_ff),
      .out_hist_one (out_hist_one_ff),
      .out_hist_two (out_hist_two_ff),
      .ff_gain      (ff_gain_ff),
      .fb_coef_one  (fb_coef_one_ff),
      .fb_coef_two  (fb_coef_two_ff),
      .filtered     (dp_filtered),
      .clipped      (dp_clipped)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_op_ff     <= req_tuser;
         s1_sample_ff <= req_tdata[SW-1:0];
      end
      if (advance) begin
         rsp_filtered_ff <= dp_filtered;
         rsp_clipped_ff  <= dp_clipped;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ff_gain_ff     <= '0;
         fb_coef_one_ff <= '0;
         fb_coef_two_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_addr)
            blbq_pkg::CSR_FF_GAIN:     ff_gain_ff     <= csr_wdata;
            blbq_pkg::CSR_FB_COEF_ONE: fb_coef_one_ff <= csr_wdata;
            blbq_pkg::CSR_FB_COEF_TWO: fb_coef_two_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_hist_one_ff  <= '0;
         in_hist_two_ff  <= '0;
         out_hist_one_ff <= '0;
         out_hist_two_ff <= '0;
      end else if (advance) begin
         if (s1_op_ff == blbq_pkg::OP_PRESET) begin
            in_hist_one_ff  <= s1_sample_ff;
            in_hist_two_ff  <= s1_sample_ff;
            out_hist_one_ff <= s1_sample_ff;
            out_hist_two_ff <= s1_sample_ff;
         end else begin
            in_hist_one_ff  <= s1_sample_ff;
            in_hist_two_ff  <= in_hist_one_ff;
            out_hist_one_ff <= dp_filtered;
            out_hist_two_ff <= out_hist_one_ff;
         end
      end
   end

   // stall only when both stages are full and the sink holds off
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (s1_valid_ff && rsp_valid_ff && !rsp_tready))
      else $error("request stalled without a full pipeline");

   a_preset_hist: assert property (@(posedge clock) disable iff (reset)
      (advance && s1_op_ff == blbq_pkg::OP_PRESET) |=>
         (in_hist_one_ff == in_hist_two_ff && in_hist_one_ff == out_hist_one_ff
          && in_hist_one_ff == out_hist_two_ff))
      else $error("preset left history taps unequal");

   a_shift_hist: assert property (@(posedge clock) disable iff (reset)
      (advance && s1_op_ff == blbq_pkg::OP_FILTER) |=>
         (in_hist_two_ff == $past(in_hist_one_ff)
          && out_hist_two_ff == $past(out_hist_one_ff)
          && out_hist_one_ff == rsp_filtered_ff))
      else $error("history taps did not shift with the result");

   a_clip_extreme: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_clipped_ff) |->
         (rsp_filtered_ff == {1'b0, {(SW-1){1'b1}}}
          || rsp_filtered_ff == {1'b1, {(SW-1){1'b0}}}))
      else $error("clipped result not at a range limit");

endmodule
`default_nettype wire

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the Butterworth low-pass biquad.
// A driver streams filter and preset requests with random gaps, a monitor
// takes results under random back-pressure and compares each one against
// a fixed-point predictor that keeps its own coefficients and history.
// Coefficients are reloaded between phases once the pipeline has drained:
// a nominal low-pass, both coefficient extremes, all zero, and random sets.
// ----------------------------------------------------------------------------
module testbench;

   localparam int SW          = 24;
   localparam int CW          = 25;
   localparam int FRAC        = 22;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_PAUSE = 4;
   localparam int RAND_PHASES = 6;
   localparam int PHASE_ITEMS = 250;
   localparam logic [blbq_pkg::CSR_ADDR_W-1:0] CSR_UNUSED = 2'd3;
   localparam logic signed [SW-1:0]  SAMPLE_MAX = 24'sh7FFFFF;
   localparam logic signed [SW-1:0]  SAMPLE_MIN = 24'sh800000;
   localparam logic signed [CW-1:0]  COEF_MAX   = 25'sh0FFFFFF;
   localparam logic signed [CW-1:0]  COEF_MIN   = 25'sh1000000;

   typedef struct packed {
      logic                 op;
      logic signed [SW-1:0] sample;
   } biquad_req_type;

   typedef struct packed {
      logic signed [SW-1:0] filtered;
      logic                 clipped;
   } biquad_rsp_type;

   logic          clock      = 1'b0;
   logic          reset      = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [SW-1:0] req_tdata  = '0;    // sample
   logic          req_tuser  = 1'b0;  // op
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [SW-1:0] rsp_tdata;          // filtered
   logic          rsp_tuser;          // clipped
   logic          csr_wr_en  = 1'b0;
   logic [blbq_pkg::CSR_ADDR_W-1:0] csr_addr  = '0;
   logic [CW-1:0]                   csr_wdata = '0;

   // predictor state
   logic signed [CW-1:0] coef_gain = '0;
   logic signed [CW-1:0] coef_fb1  = '0;
   logic signed [CW-1:0] coef_fb2  = '0;
   logic signed [SW-1:0] tap_x1 = '0, tap_x2 = '0, tap_y1 = '0, tap_y2 = '0;

   biquad_req_type pending_q[$];
   biquad_rsp_type expected_q[$];
   biquad_req_type on_bus;
   int  issued_count   = 0;
   int  accepted_count = 0;
   int  checked_count  = 0;
   int  preset_count   = 0;
   int  clip_count     = 0;
   int  error_count    = 0;
   int  setting_count  = 0;
   int  cycle_count    = 0;
   int  send_gap       = 0;
   int  recv_gap       = 0;
   bit  steady         = 1'b0;

   butterworth_lowpass_biquad_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wr_en  (csr_wr_en),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int next_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // direct form I step (or preset of all four taps): exact sum, round half-up, saturate, feed back
   function automatic biquad_rsp_type biquad_predict(biquad_req_type item);
      biquad_rsp_type res;
      longint         taps, acc, rnd;
      res.clipped = 1'b0;
      if (item.op == blbq_pkg::OP_PRESET) begin
         tap_x1 = item.sample;
         tap_x2 = item.sample;
         tap_y1 = item.sample;
         tap_y2 = item.sample;
         res.filtered = item.sample;
         preset_count++;
      end else begin
         taps = longint'(item.sample) + 2 * longint'(tap_x1) + longint'(tap_x2);
         acc  = longint'(coef_gain) * taps - longint'(coef_fb1) * longint'(tap_y1)
                - longint'(coef_fb2) * longint'(tap_y2);
         rnd  = (acc + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
         if (rnd > longint'(SAMPLE_MAX)) begin
            res.filtered = SAMPLE_MAX;
            res.clipped  = 1'b1;
         end else if (rnd < longint'(SAMPLE_MIN)) begin
            res.filtered = SAMPLE_MIN;
            res.clipped  = 1'b1;
         end else begin
            res.filtered = rnd[SW-1:0];
         end
         tap_x2 = tap_x1;
         tap_x1 = item.sample;
         tap_y2 = tap_y1;
         tap_y1 = res.filtered;
      end
      return res;
   endfunction

   task automatic report_mismatch(input string what, input longint want, input longint got);
      $display("[%0t] mismatch %s: expected %0d got %0d (result %0d)",
               $time, what, want, got, checked_count);
      error_count++;
   endtask

   // driver
   always @(posedge clock) begin : request_driver
      biquad_req_type item;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_q.push_back(biquad_predict(on_bus));
            accepted_count++;
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_q.size() > 0) begin
               item = pending_q.pop_front();
               on_bus = item;
               req_tdata  <= item.sample;
               req_tuser  <= item.op;
               req_tvalid <= 1'b1;
               send_gap = next_gap();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin : result_monitor
      biquad_rsp_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_q.size() == 0) begin
               report_mismatch("unexpected result", 0, longint'($signed(rsp_tdata)));
            end else begin
               want = expected_q.pop_front();
               if (rsp_tdata !== want.filtered)
                  report_mismatch("filtered", longint'(want.filtered),
                                  longint'($signed(rsp_tdata)));
               if (rsp_tuser !== want.clipped)
                  report_mismatch("clipped", longint'(want.clipped), longint'(rsp_tuser));
               if (want.clipped) clip_count++;
            end
            checked_count++;
         end
         if (recv_gap > 0) begin
            recv_gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            recv_gap = next_gap();
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, expected_q.size());
         $display("testbench: FAIL");
         $finish;
      end
   end

   task automatic queue_item(input logic op, input logic signed [SW-1:0] sample);
      biquad_req_type item;
      item.op     = op;
      item.sample = sample;
      pending_q.push_back(item);
      issued_count++;
   endtask

   task automatic drain();
      while (!(accepted_count == issued_count && expected_q.size() == 0))
         @(posedge clock);
      repeat (DRAIN_PAUSE) @(posedge clock);
   endtask

   task automatic write_csr(input logic [blbq_pkg::CSR_ADDR_W-1:0] addr,
                            input logic [CW-1:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= value;
      case (addr)
         blbq_pkg::CSR_FF_GAIN:     coef_gain = value;
         blbq_pkg::CSR_FB_COEF_ONE: coef_fb1  = value;
         blbq_pkg::CSR_FB_COEF_TWO: coef_fb2  = value;
         default: ;
      endcase
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic load_coefs(input logic [CW-1:0] g, input logic [CW-1:0] c1,
                             input logic [CW-1:0] c2);
      drain();
      write_csr(blbq_pkg::CSR_FF_GAIN, g);
      write_csr(blbq_pkg::CSR_FB_COEF_ONE, c1);
      write_csr(blbq_pkg::CSR_FB_COEF_TWO, c2);
      setting_count++;
   endtask

   function automatic logic signed [SW-1:0] random_sample();
      int r;
      r = $urandom_range(0, 19);
      if (r == 0) return SAMPLE_MAX;
      if (r == 1) return SAMPLE_MIN;
      if (r < 5)  return $signed(24'($urandom_range(0, 200))) - 24'sd100;
      return SW'($urandom());
   endfunction

   initial begin : stimulus
      int c2_mag;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // nominal low-pass, cutoff at a tenth of the sample rate
      load_coefs(25'sd282943, -25'sd4794090, 25'sd1731410);
      queue_item(blbq_pkg::OP_PRESET, 24'sd0);
      repeat (4) queue_item(blbq_pkg::OP_FILTER, SAMPLE_MAX);
      repeat (2) queue_item(blbq_pkg::OP_FILTER, SAMPLE_MIN);
      queue_item(blbq_pkg::OP_FILTER, 24'sd0);
      queue_item(blbq_pkg::OP_FILTER, -24'sd1);
      queue_item(blbq_pkg::OP_FILTER, 24'sd1);
      queue_item(blbq_pkg::OP_PRESET, SAMPLE_MIN);
      queue_item(blbq_pkg::OP_FILTER, SAMPLE_MIN);

      // extreme coefficients, drive both saturation rails
      load_coefs(COEF_MAX, COEF_MIN, COEF_MAX);
      queue_item(blbq_pkg::OP_PRESET, SAMPLE_MAX);
      queue_item(blbq_pkg::OP_FILTER, SAMPLE_MAX);
      queue_item(blbq_pkg::OP_PRESET, SAMPLE_MIN);
      queue_item(blbq_pkg::OP_FILTER, SAMPLE_MIN);
      queue_item(blbq_pkg::OP_FILTER, 24'sd0);
      queue_item(blbq_pkg::OP_FILTER, 24'sd1);

      // opposite extremes; a write past the register list must be ignored
      load_coefs(COEF_MIN, COEF_MAX, COEF_MIN);
      write_csr(CSR_UNUSED, CW'($urandom()));
      queue_item(blbq_pkg::OP_FILTER, SAMPLE_MAX);
      queue_item(blbq_pkg::OP_FILTER, SAMPLE_MIN);
      queue_item(blbq_pkg::OP_PRESET, 24'sd1);
      queue_item(blbq_pkg::OP_FILTER, -24'sd1);

      load_coefs('0, '0, '0);
      queue_item(blbq_pkg::OP_FILTER, SAMPLE_MAX);
      queue_item(blbq_pkg::OP_FILTER, SAMPLE_MIN);
      queue_item(blbq_pkg::OP_PRESET, 24'sd123);

      for (int p = 0; p < RAND_PHASES; p++) begin
         case (p % 3)
            0: begin
               // stable low-pass shape with random values
               c2_mag = $urandom_range(0, 3774873);
               load_coefs(CW'($urandom_range(1, 1 << 20)),
                          CW'(-$signed($urandom_range(0, (1 << FRAC) + c2_mag - 1))),
                          CW'(c2_mag));
            end
            1: load_coefs(CW'($urandom()), CW'($urandom()), CW'($urandom()));
            default: load_coefs($signed(25'($urandom_range(0, 1 << 21))) - 25'sd1048576,
                                $signed(25'($urandom_range(0, 1 << 21))) - 25'sd1048576,
                                $signed(25'($urandom_range(0, 1 << 21))) - 25'sd1048576);
         endcase
         steady = (p == 2 || p == 4);
         if (p == 3) write_csr(CSR_UNUSED, CW'($urandom()));
         for (int i = 0; i < PHASE_ITEMS; i++)
            queue_item(($urandom_range(0, 24) == 0) ? blbq_pkg::OP_PRESET
                                                    : blbq_pkg::OP_FILTER,
                       random_sample());
      end

      drain();
      repeat (8) @(posedge clock);
      $display("covered %0d requests (%0d presets) over %0d coefficient settings",
               accepted_count, preset_count, setting_count);
      $display("checked %0d results, %0d of them saturated, %0d mismatches",
               checked_count, clip_count, error_count);
      if (error_count == 0 && expected_q.size() == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end
endmodule

@@ filelist.f @@
hdl/blbq_pkg.sv
hdl/blbq_datapath.sv
hdl/butterworth_lowpass_biquad_top.sv
verif/testbench.sv
